// File: rtl/tlfd_pkg.sv
`default_nettype none
package tlfd_pkg;

  // header layout
  localparam int unsigned HdrBytes   = 9;
  localparam int unsigned CntW       = 4;
  localparam logic [CntW-1:0] HdrLast    = CntW'(HdrBytes - 1);
  localparam logic [CntW-1:0] StreamLast = CntW'(4);

  // configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] RegMaxPayload = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCodeData   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCodeOpen   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegCodeClose  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegCodePing   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegCodeFault  = 3'd5;

  // result kinds
  localparam logic [1:0] KindHeader = 2'd0;
  localparam logic [1:0] KindData   = 2'd1;
  localparam logic [1:0] KindError  = 2'd2;

  // error codes
  localparam logic ErrType   = 1'b0;
  localparam logic ErrLength = 1'b1;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_HALT    = 2'd2
  } phase_e;

  typedef struct packed {
    logic [31:0] max_payload;
    logic [7:0]  code_data;
    logic [7:0]  code_open;
    logic [7:0]  code_close;
    logic [7:0]  code_ping;
    logic [7:0]  code_fault;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  frame_type;
    logic [31:0] stream_number;
    logic [31:0] payload_length;
    logic [7:0]  data_byte;
    logic        last;
    logic        error_code;
  } result_t;

endpackage
`default_nettype wire

// File: rtl/type_length_frame_deframer.sv
`default_nettype none
// channel  direction  handshake                 payload
// in       input      in_valid_i / in_stall_o   in_byte_i
// out      output     out_valid_o / out_stall_i kind_o .. error_code_o
// cfg      input      cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// one byte per cycle in while in_stall_o is low; each byte is decoded in the cycle it is taken,
// and any word that it completes is registered into a two-entry output queue.
// in_stall_o rises only when both queue entries hold undelivered words.
// reset clears the header state and the queue and loads register defaults.
// after an error word the block swallows all bytes until reset.
module type_length_frame_deframer (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [7:0]                   in_byte_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [1:0]                        kind_o,
  output logic [7:0]                        frame_type_o,
  output logic [31:0]                       stream_number_o,
  output logic [31:0]                       payload_length_o,
  output logic [7:0]                        data_byte_o,
  output logic                              last_o,
  output logic                              error_code_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [tlfd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [31:0]                  cfg_wdata_i
);
  import tlfd_pkg::*;

  cfg_t    cfg;
  result_t res;
  result_t out_word;
  logic    res_valid;
  logic    buf_full;
  logic    in_take;

  assign in_stall_o = buf_full;
  assign in_take    = in_valid_i && !buf_full;

  tlfd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  tlfd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_take),
    .byte_i      (in_byte_i),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  tlfd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (buf_full),
    .valid_o     (out_valid_o),
    .stall_i     (out_stall_i),
    .data_o      (out_word)
  );

  // unpack the result word
  assign kind_o           = out_word.kind;
  assign frame_type_o     = out_word.frame_type;
  assign stream_number_o  = out_word.stream_number;
  assign payload_length_o = out_word.payload_length;
  assign data_byte_o      = out_word.data_byte;
  assign last_o           = out_word.last;
  assign error_code_o     = out_word.error_code;

endmodule
`default_nettype wire

// File: rtl/tlfd_cfg_regs.sv
`default_nettype none
module tlfd_cfg_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [tlfd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [31:0]                 cfg_wdata_i,
  output tlfd_pkg::cfg_t                   cfg_o
);
  import tlfd_pkg::*;

  cfg_t cfg_q, cfg_d;

  // register write decode, unknown indexes are ignored
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegMaxPayload: cfg_d.max_payload = cfg_wdata_i;
        RegCodeData:   cfg_d.code_data   = cfg_wdata_i[7:0];
        RegCodeOpen:   cfg_d.code_open   = cfg_wdata_i[7:0];
        RegCodeClose:  cfg_d.code_close  = cfg_wdata_i[7:0];
        RegCodePing:   cfg_d.code_ping   = cfg_wdata_i[7:0];
        RegCodeFault:  cfg_d.code_fault  = cfg_wdata_i[7:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_payload <= 32'hFFFF_FFFF;
      cfg_q.code_data   <= 8'd0;
      cfg_q.code_open   <= 8'd1;
      cfg_q.code_close  <= 8'd2;
      cfg_q.code_ping   <= 8'd3;
      cfg_q.code_fault  <= 8'd4;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// File: rtl/tlfd_parser.sv
`default_nettype none
module tlfd_parser (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire logic [7:0]    byte_i,
  input  tlfd_pkg::cfg_t     cfg_i,
  output logic               res_valid_o,
  output tlfd_pkg::result_t  res_o
);
  import tlfd_pkg::*;

  phase_e          phase_q, phase_d;
  logic [CntW-1:0] count_q, count_d;
  logic [7:0]      type_q, type_d;
  logic [31:0]     stream_q, stream_d;
  logic [31:0]     length_q, length_d;
  logic [31:0]     rem_q, rem_d;

  logic hdr_done;
  logic type_ok;
  logic len_ok;
  logic rem_last;

  // header field assembly, big-endian
  always_comb begin
    type_d   = type_q;
    stream_d = stream_q;
    length_d = length_q;
    if (phase_q == PH_HEADER) begin
      if (count_q == '0) begin
        type_d = byte_i;
      end else if (count_q <= StreamLast) begin
        stream_d = {stream_q[23:0], byte_i};
      end else begin
        length_d = {length_q[23:0], byte_i};
      end
    end
  end

  // header checks on the freshly assembled fields
  assign hdr_done = (phase_q == PH_HEADER) && (count_q == HdrLast);
  assign type_ok  = (type_d == cfg_i.code_data)  || (type_d == cfg_i.code_open) ||
                    (type_d == cfg_i.code_close) || (type_d == cfg_i.code_ping) ||
                    (type_d == cfg_i.code_fault);
  assign len_ok   = (length_d <= cfg_i.max_payload);
  assign rem_last = (rem_q == 32'd1);

  // next state
  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    rem_d   = rem_q;
    unique case (phase_q)
      PH_HEADER: begin
        if (hdr_done) begin
          count_d = '0;
          priority if (!type_ok || !len_ok) begin
            phase_d = PH_HALT;
          end else if (length_d != 32'd0) begin
            phase_d = PH_PAYLOAD;
            rem_d   = length_d;
          end else begin
            // empty frame, next header follows
            phase_d = PH_HEADER;
          end
        end else begin
          count_d = count_q + CntW'(1);
        end
      end
      PH_PAYLOAD: begin
        rem_d = rem_q - 32'd1;
        if (rem_last) begin
          phase_d = PH_HEADER;
        end
      end
      default: phase_d = phase_q;
    endcase
  end

  // result word
  always_comb begin
    res_valid_o          = 1'b0;
    res_o.kind           = KindHeader;
    res_o.frame_type     = type_d;
    res_o.stream_number  = stream_d;
    res_o.payload_length = length_d;
    res_o.data_byte      = 8'd0;
    res_o.last           = 1'b0;
    res_o.error_code     = ErrType;
    unique case (phase_q)
      PH_HEADER: begin
        res_valid_o = push_i && hdr_done;
        priority if (!type_ok) begin
          res_o.kind = KindError;
        end else if (!len_ok) begin
          res_o.kind       = KindError;
          res_o.error_code = ErrLength;
        end else begin
          res_o.last = (length_d == 32'd0);
        end
      end
      PH_PAYLOAD: begin
        res_valid_o     = push_i;
        res_o.kind      = KindData;
        res_o.data_byte = byte_i;
        res_o.last      = rem_last;
      end
      default: res_valid_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      count_q  <= '0;
      type_q   <= 8'd0;
      stream_q <= 32'd0;
      length_q <= 32'd0;
      rem_q    <= 32'd0;
    end else if (push_i) begin
      phase_q  <= phase_d;
      count_q  <= count_d;
      type_q   <= type_d;
      stream_q <= stream_d;
      length_q <= length_d;
      rem_q    <= rem_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/tlfd_out_buf.sv
`default_nettype none
module tlfd_out_buf (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  tlfd_pkg::result_t  push_data_i,
  output logic               full_o,
  output logic               valid_o,
  input  wire logic          stall_i,
  output tlfd_pkg::result_t  data_o
);
  import tlfd_pkg::*;

  // two-entry queue: a ring of two entries with read and write pointers
  result_t    ent_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign pop     = valid_o && !stall_i;
  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign data_o  = ent_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    unique case ({push_i, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop)    rd_ptr_q <= ~rd_ptr_q;
    end
  end

  // payload storage
  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wr_ptr_q] <= push_data_i;
  end

endmodule
`default_nettype wire
